>>> rtl/core/grc_pkg.sv
package grc_pkg;

  localparam int unsigned MapCellsDef = 1048576;
  localparam int unsigned MaxSpanDef  = 8191;

  localparam int unsigned IdxW   = 20;
  localparam int unsigned CntW   = 13;
  localparam int unsigned StrW   = 14;
  localparam int unsigned DimW   = 13;
  localparam int unsigned DistW  = 22;
  localparam logic [DistW-1:0] DistMax = '1;

  // span squares sum below 2^27, shifted by 16 -> 43 bits, root below 2^22
  localparam int unsigned SqW    = 27;
  localparam int unsigned RadW   = 44;
  localparam int unsigned RootW  = 22;

  localparam logic OpWrite = 1'b0;
  localparam logic OpCast  = 1'b1;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StPrep,
    StRead,
    StWait,
    StCheck,
    StDivA,
    StDivB,
    StSq,
    StSqrt,
    StDone
  } state_e;

  // request to the shared divider
  typedef struct packed {
    logic            start;
    logic [IdxW-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [IdxW-1:0] quot;
    logic [IdxW-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [RadW-1:0]  radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } sqrt_rsp_t;

endpackage

>>> rtl/core/grid_ray_cast_to_obstacle_core.sv
// Occupancy-grid ray caster. A write request (opcode 0) stores one cell bit.
// A cast request (opcode 1) walks the ray one cell at a time (bounds check, map
// read, check and step) through the grid memory, then splits the start and end
// indices by map_width on a bit-serial divider, squares and takes a bit-serial
// square root. A ray that starts off the map, or a ray that walks its full span
// with no obstacle, skips the divide. busy is high throughout; done_o strobes
// the result for one cycle and cannot be held off by the receiver.
// Cells must be written before a ray reads them.
module grid_ray_cast_to_obstacle_core #(
  parameter int unsigned MAP_CELLS = grc_pkg::MapCellsDef,
  parameter int unsigned MAX_SPAN  = grc_pkg::MaxSpanDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [grc_pkg::DimW-1:0]      cfg_data_i,
  input  logic                          opcode_i,
  input  logic [grc_pkg::IdxW-1:0]      cell_index_i,
  input  logic                          occupied_i,
  input  logic [grc_pkg::CntW-1:0]      major_count_i,
  input  logic [grc_pkg::CntW-1:0]      minor_count_i,
  input  logic signed [grc_pkg::StrW-1:0] major_stride_i,
  input  logic signed [grc_pkg::StrW-1:0] minor_stride_i,
  output logic                          done_o,
  output logic [grc_pkg::DistW-1:0]     distance_o,
  output logic                          hit_o,
  output logic                          left_map_o
);
  import grc_pkg::*;

  localparam int unsigned AddrW = $clog2(MAP_CELLS);
  localparam int unsigned PosW  = 26;
  localparam logic [PosW-1:0] CellsCap = PosW'(MAP_CELLS);
  localparam logic [CntW-1:0] SpanCap  =
    (MAX_SPAN >= (1 << CntW)) ? '1 : CntW'(MAX_SPAN);

  logic mem [MAP_CELLS];
  logic rd_q;
  logic             mem_we;

  logic [DimW-1:0] width_q, height_q;
  state_e state_q, state_d;

  logic signed [PosW-1:0] pos_q, pos_d, last_q, last_d, start_q, start_d;
  logic signed [PosW-1:0] err_q, err_d;
  logic [CntW-1:0] a_q, a_d, b_q, b_d, i_q, i_d;
  logic signed [StrW-1:0] sa_q, sa_d, sb_q, sb_d;
  logic [PosW-1:0] cells_q, cells_d;
  logic hit_q, hit_d, left_q, left_d, zero_q, zero_d, fin_q, fin_d;
  logic [IdxW-1:0] qa_q, qa_d, ra_q, ra_d;
  logic [SqW-1:0] sq_q, sq_d;
  logic [DimW-1:0] w_eff;
  logic [2*DimW-1:0] cells_w;
  logic signed [PosW-1:0] pos_step, err_step, dx, dy;
  logic [IdxW-1:0] end_idx;
  logic [SqW-1:0] ax, ay;

  div_req_t div_req;
  div_rsp_t div_rsp;
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  grc_div u_div (.clk_i, .rst_ni, .req_i(div_req), .divisor_i(w_eff), .rsp_o(div_rsp));
  grc_sqrt u_sqrt (.clk_i, .rst_ni, .req_i(sq_req), .rsp_o(sq_rsp));

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
    if (v == '0) return DimW'(1);
    if (v > DimW'(4096)) return DimW'(4096);
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(1024);
      height_q <= DimW'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegWidth:  width_q  <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_dim(width_q);
  assign cells_w = w_eff * clamp_dim(height_q);
  assign mem_we = start && !busy && opcode_i == OpWrite && 26'(cell_index_i) < CellsCap;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[AddrW'(cell_index_i)] <= occupied_i;
    rd_q <= mem[pos_q[AddrW-1:0]];
  end

  assign end_idx = hit_q ? pos_q[IdxW-1:0] : last_q[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    pos_d = pos_q; last_d = last_q; start_d = start_q; err_d = err_q;
    a_d = a_q; b_d = b_q; i_d = i_q; sa_d = sa_q; sb_d = sb_q;
    cells_d = cells_q; hit_d = hit_q; left_d = left_q; zero_d = zero_q;
    fin_d = 1'b0;
    qa_d = qa_q; ra_d = ra_q; sq_d = sq_q;
    div_req = '0;
    sq_req = '0;
    pos_step = pos_q + PosW'(sa_q);
    err_step = err_q + PosW'(b_q);
    dx = '0; dy = '0; ax = '0; ay = '0;
    unique case (state_q)
      StIdle: begin
        if (start && opcode_i == OpCast) begin
          start_d = PosW'(cell_index_i);
          pos_d = PosW'(cell_index_i);
          last_d = PosW'(cell_index_i);
          a_d = (major_count_i > SpanCap) ? SpanCap : major_count_i;
          b_d = (minor_count_i > SpanCap) ? SpanCap : minor_count_i;
          sa_d = major_stride_i; sb_d = minor_stride_i;
          err_d = '0; i_d = '0;
          hit_d = 1'b0; left_d = 1'b0; zero_d = 1'b0;
          cells_d = (PosW'(cells_w) > CellsCap) ? CellsCap : PosW'(cells_w);
          state_d = StPrep;
        end else if (start) begin
          state_d = StDone;
        end
      end
      StPrep: begin
        if (pos_q < 0 || pos_q >= $signed(cells_q)) begin
          left_d = 1'b1;
          if (i_q == '0) begin
            zero_d = 1'b1;
            fin_d = 1'b1;
            state_d = StDone;
          end else begin
            state_d = StDivA;
          end
        end else begin
          state_d = StRead;
        end
      end
      StRead: state_d = StCheck;
      StCheck: begin
        if (rd_q) begin
          hit_d = 1'b1;
          state_d = StDivA;
        end else begin
          last_d = pos_q;
          if ($signed(err_step - PosW'(a_q >> 1)) > 0) begin
            err_d = err_step - PosW'(a_q);
            pos_d = pos_step + PosW'(sb_q);
          end else begin
            err_d = err_step;
            pos_d = pos_step;
          end
          if (i_q == a_q) begin
            sq_d = SqW'(a_q) * SqW'(a_q) + SqW'(b_q) * SqW'(b_q);
            state_d = StSqrt;
            sq_req.start = 1'b1;
            sq_req.radicand = RadW'({sq_d, 16'b0});
          end else begin
            i_d = i_q + CntW'(1);
            state_d = StPrep;
          end
        end
      end
      StDivA: begin
        div_req.start = !div_rsp.done && !zero_q;
        div_req.dividend = start_q[IdxW-1:0];
        zero_d = 1'b1; // marks divider launched
        if (div_rsp.done) begin
          qa_d = div_rsp.quot; ra_d = div_rsp.rem;
          zero_d = 1'b0;
          state_d = StDivB;
        end
      end
      StDivB: begin
        div_req.start = !zero_q;
        div_req.dividend = end_idx;
        zero_d = 1'b1;
        if (div_rsp.done && zero_q) begin
          zero_d = 1'b0;
          state_d = StSq;
          dx = PosW'(div_rsp.rem) - PosW'(ra_q);
          dy = PosW'(div_rsp.quot) - PosW'(qa_q);
          qa_d = IdxW'(dx < 0 ? -dx : dx);
          ra_d = IdxW'(dy < 0 ? -dy : dy);
        end
      end
      StSq: begin
        ax = SqW'(qa_q);
        ay = SqW'(ra_q);
        sq_d = ax * ax + ay * ay;
        sq_req.start = 1'b1;
        sq_req.radicand = RadW'({sq_d, 16'b0});
        state_d = StSqrt;
      end
      StSqrt: begin
        if (sq_rsp.done) begin
          fin_d = 1'b1;
          state_d = StDone;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; last_q <= last_d; start_q <= start_d; err_q <= err_d;
    a_q <= a_d; b_q <= b_d; i_q <= i_d; sa_q <= sa_d; sb_q <= sb_d;
    cells_q <= cells_d; hit_q <= hit_d; left_q <= left_d; zero_q <= zero_d;
    qa_q <= qa_d; ra_q <= ra_d; sq_q <= sq_d;
    if (fin_d) distance_o <= (state_q == StPrep) ? '0
      : ((sq_rsp.root > RootW'(DistMax)) ? DistMax : DistW'(sq_rsp.root));
  end

  assign busy = state_q != StIdle;
  assign done_o = fin_q;
  assign hit_o = hit_q;
  assign left_map_o = left_q;

`ifndef SYNTHESIS
  a_done_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without request");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && left_map_o)) else $error("hit and left_map both set");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result");
`endif
endmodule

>>> rtl/core/grc_div.sv
// restoring divider, one quotient bit per cycle
module grc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grc_pkg::div_req_t  req_i,
  input  logic [grc_pkg::DimW-1:0] divisor_i,
  output grc_pkg::div_rsp_t  rsp_o
);
  import grc_pkg::*;

  logic [IdxW-1:0] quot_q, quot_d;
  logic [DimW:0]   rem_q, rem_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DimW+1:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[IdxW-1]} - {2'b0, divisor_i};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      cnt_d  = 5'(IdxW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DimW+1]) begin
        rem_d = trial[DimW:0];
        quot_d = {quot_q[IdxW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DimW-1:0], quot_q[IdxW-1]};
        quot_d = {quot_q[IdxW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = IdxW'(rem_q);
endmodule

>>> rtl/core/grc_sqrt.sv
// bitwise integer square root, one result bit per cycle
module grc_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grc_pkg::sqrt_req_t req_i,
  output grc_pkg::sqrt_rsp_t rsp_o
);
  import grc_pkg::*;

  logic [RadW-1:0] v_q, v_d, res_q, res_d, bit_q, bit_d, sum;
  logic            busy_q, busy_d, done_q, done_d;

  always_comb begin
    v_d = v_q;
    res_d = res_q;
    bit_d = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sum = res_q + bit_q;
    if (req_i.start) begin
      v_d = req_i.radicand;
      res_d = '0;
      bit_d = RadW'(1) << (RadW - 2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (v_q >= sum) begin
        v_d = v_q - sum;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[RootW-1:0];
endmodule

>>> test/grid_ray_cast_to_obstacle_core_tb.sv
`timescale 1ns / 1ps

module grid_ray_cast_to_obstacle_core_tb;
  import grc_pkg::*;

  localparam int unsigned GridCells = MapCellsDef;
  localparam int unsigned SpanMax   = MaxSpanDef;

  typedef enum logic [1:0] {RowCfg, RowWrite, RowCast} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic       cfg_idx;
    int         cfg_val;
    int         idx;
    bit         occ;
    int         maj;
    int         mnr;
    int         s_maj;
    int         s_mnr;
    bit         typed;
    int         t_dist;
    bit         t_hit;
    bit         t_left;
  } stim_row_t;

  typedef struct {
    logic [DistW-1:0] distance;
    logic             hit;
    logic             left_map;
  } ray_result_t;

  logic clk_i, rst_ni, start, busy, cfg_we_i, cfg_index_i;
  logic [DimW-1:0] cfg_data_i;
  logic opcode_i, occupied_i, done_o, hit_o, left_map_o;
  logic [IdxW-1:0] cell_index_i;
  logic [CntW-1:0] major_count_i, minor_count_i;
  logic signed [StrW-1:0] major_stride_i, minor_stride_i;
  logic [DistW-1:0] distance_o;

  grid_ray_cast_to_obstacle_core u_top (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .opcode_i, .cell_index_i, .occupied_i, .major_count_i, .minor_count_i,
    .major_stride_i, .minor_stride_i, .done_o, .distance_o, .hit_o, .left_map_o
  );

  bit grid_occ [0:GridCells-1];
  bit grid_known [0:GridCells-1];
  logic [DimW-1:0] width_reg, height_reg;
  ray_result_t pending_rays[$];
  int errors, n_casts, n_writes, n_hits, n_left, n_cfg;
  int density;
  bit idle_on;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("grid_ray_cast_to_obstacle_core_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    ray_result_t e;
    if (rst_ni && done_o) begin
      if (pending_rays.size() == 0) begin
        report_mismatch("unexpected result, distance", distance_o, -1);
      end else begin
        e = pending_rays.pop_front();
        if (distance_o !== e.distance) report_mismatch("distance", distance_o, e.distance);
        if (hit_o !== e.hit) report_mismatch("hit", hit_o, e.hit);
        if (left_map_o !== e.left_map) report_mismatch("left_map", left_map_o, e.left_map);
        if (e.hit) n_hits++;
        if (e.left_map) n_left++;
      end
    end
  end

  function automatic longint eff_dim(logic [DimW-1:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function automatic longint map_cells();
    longint c;
    c = eff_dim(width_reg) * eff_dim(height_reg);
    return (c > GridCells) ? GridCells : c;
  endfunction

  // floor(sqrt(sq << 16)), saturated to the output width
  function automatic logic [DistW-1:0] q8_length(longint unsigned sq);
    longint unsigned v, res, b;
    v = sq << 16;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return (res > DistMax) ? DistMax : res[DistW-1:0];
  endfunction

  function automatic logic [DistW-1:0] cell_gap(longint a, longint b, longint w);
    longint dx, dy;
    dx = (b % w) - (a % w);
    dy = (b / w) - (a / w);
    return q8_length(dx * dx + dy * dy);
  endfunction

  // Bresenham walk; reports the first never-written cell it would read
  function automatic ray_result_t trace_ray(int idx, int maj, int mnr, int s_maj,
                                            int s_mnr, output longint unknown);
    ray_result_t r;
    longint a, b, w, cells, pos, last, err;
    a = (maj > SpanMax) ? SpanMax : maj;
    b = (mnr > SpanMax) ? SpanMax : mnr;
    w = eff_dim(width_reg);
    cells = map_cells();
    pos = idx;
    last = idx;
    err = 0;
    unknown = -1;
    r.distance = q8_length(a * a + b * b);
    r.hit = 1'b0;
    r.left_map = 1'b0;
    for (longint i = 0; i <= a; i++) begin
      if (pos < 0 || pos >= cells) begin
        r.left_map = 1'b1;
        r.distance = (i == 0) ? '0 : cell_gap(idx, last, w);
        break;
      end
      if (!grid_known[pos]) begin
        unknown = pos;
        break;
      end
      if (grid_occ[pos]) begin
        r.hit = 1'b1;
        r.distance = cell_gap(idx, pos, w);
        break;
      end
      last = pos;
      pos += s_maj;
      err += b;
      if (err - a / 2 > 0) begin
        err -= a;
        pos += s_mnr;
      end
    end
    return r;
  endfunction

  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
    end
  endtask

  // drives one request and returns once it has been taken
  task automatic issue(bit cast, int idx, bit occ, int maj, int mnr, int s_maj, int s_mnr);
    logic b;
    @(negedge clk_i);
    start <= 1'b1;
    opcode_i <= cast ? OpCast : OpWrite;
    cell_index_i <= idx[IdxW-1:0];
    occupied_i <= occ;
    major_count_i <= maj[CntW-1:0];
    minor_count_i <= mnr[CntW-1:0];
    major_stride_i <= s_maj[StrW-1:0];
    minor_stride_i <= s_mnr[StrW-1:0];
    forever begin
      #1 b = busy;
      @(posedge clk_i);
      if (!b) break;
      @(negedge clk_i);
    end
  endtask

  task automatic write_cell(int idx, bit occ);
    issue(1'b0, idx, occ, $urandom_range(0, 8191), $urandom_range(0, 8191),
          $urandom_range(0, 16383), $urandom_range(0, 16383));
    grid_occ[idx] = occ;
    grid_known[idx] = 1'b1;
    n_writes++;
  endtask

  task automatic cast_ray(stim_row_t r);
    ray_result_t e;
    longint unknown;
    forever begin
      e = trace_ray(r.idx, r.maj, r.mnr, r.s_maj, r.s_mnr, unknown);
      if (unknown < 0) break;
      write_cell(int'(unknown), $urandom_range(0, 99) < density);
    end
    if (r.typed) begin
      e.distance = r.t_dist;
      e.hit = r.t_hit;
      e.left_map = r.t_left;
    end
    issue(1'b1, r.idx, $urandom_range(0, 1), r.maj, r.mnr, r.s_maj, r.s_mnr);
    pending_rays.push_back(e);
    n_casts++;
  endtask

  task automatic write_reg(logic idx, int val);
    @(negedge clk_i);
    start <= 1'b0;
    wait (pending_rays.size() == 0);
    repeat (8) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[DimW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegWidth) width_reg = val[DimW-1:0];
    else height_reg = val[DimW-1:0];
    n_cfg++;
  endtask

  task automatic run_row(stim_row_t r);
    case (r.kind)
      RowCfg:   write_reg(r.cfg_idx, r.cfg_val);
      RowWrite: write_cell(r.idx, r.occ);
      default:  cast_ray(r);
    endcase
  endtask

  function automatic stim_row_t mk(row_kind_e k, int idx, int occ, int maj, int mnr,
                                   int s_maj, int s_mnr, bit typed = 0, int td = 0,
                                   bit th = 0, bit tl = 0);
    stim_row_t r;
    r.kind = k; r.cfg_idx = occ[0]; r.cfg_val = idx;
    r.idx = idx; r.occ = occ[0]; r.maj = maj; r.mnr = mnr;
    r.s_maj = s_maj; r.s_mnr = s_mnr;
    r.typed = typed; r.t_dist = td; r.t_hit = th; r.t_left = tl;
    return r;
  endfunction

  function automatic int pick_stride(longint w);
    int s;
    case ($urandom_range(0, 5))
      0: s = 1;
      1: s = int'(w);
      2: s = int'(w) + 1;
      3: s = 0;
      default: s = $urandom_range(0, 8192) - 4096;
    endcase
    if (s > 4096) s = 4096;
    return $urandom_range(0, 1) ? s : -s;
  endfunction

  initial begin
    stim_row_t directed[$];
    stim_row_t r;
    int phase_w[6] = '{16, 4096, 0, 100, 8191, 37};
    int phase_h[6] = '{16, 4096, 4096, 7, 1, 5};
    longint cells;
    int span;

    rst_ni = 1'b0; start = 1'b0; cfg_we_i = 1'b0; cfg_index_i = RegWidth;
    cfg_data_i = '0; opcode_i = OpWrite; cell_index_i = '0; occupied_i = 1'b0;
    major_count_i = '0; minor_count_i = '0; major_stride_i = '0; minor_stride_i = '0;
    width_reg = 1024; height_reg = 1024;
    density = 20; idle_on = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // RowCfg rows: register value in idx, register index in occ
    directed = '{
      mk(RowWrite, 0, 0, 0, 0, 0, 0),
      mk(RowWrite, 1, 1, 0, 0, 0, 0),
      mk(RowWrite, 1048575, 0, 0, 0, 0, 0),
      mk(RowCast, 0, 0, 1, 0, 1, 0, 1, 256, 1, 0),
      mk(RowCast, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0),
      mk(RowCast, 0, 0, 3, 0, -1, 0, 1, 0, 0, 1),
      mk(RowCast, 1048575, 0, 0, 0, 1, 0, 1, 0, 0, 0),
      mk(RowCast, 1048575, 0, 2, 0, 1, 0, 1, 0, 0, 1),
      mk(RowCast, 0, 0, 8191, 8191, 0, 0),
      mk(RowCast, 1, 0, 5, 5, 1, 1, 1, 0, 1, 0),
      mk(RowCfg, 0, RegWidth, 0, 0, 0, 0),
      mk(RowCfg, 0, RegHeight, 0, 0, 0, 0),
      mk(RowCast, 5, 0, 0, 0, 1, 0, 1, 0, 0, 1),
      mk(RowCast, 0, 0, 4, 0, 1, 0, 1, 0, 0, 1),
      mk(RowCfg, 8191, RegWidth, 0, 0, 0, 0),
      mk(RowCfg, 8191, RegHeight, 0, 0, 0, 0),
      mk(RowCast, 1048575, 0, 3, 2, -1, -4096),
      mk(RowWrite, 1048575, 1, 0, 0, 0, 0),
      mk(RowCast, 1048575, 0, 8191, 0, 4096, 0, 1, 0, 1, 0),
      mk(RowCfg, 3, RegWidth, 0, 0, 0, 0),
      mk(RowCfg, 4, RegHeight, 0, 0, 0, 0),
      mk(RowCast, 0, 0, 6, 2, 1, 3),
      mk(RowCast, 11, 0, 9, 4, -1, -3)
    };
    foreach (directed[i]) run_row(directed[i]);

    for (int p = 0; p < 6; p++) begin
      write_reg(RegWidth, phase_w[p]);
      write_reg(RegHeight, phase_h[p]);
      // dense enough that walks stop early and few cells need filling
      density = $urandom_range(20, 45);
      idle_on = (p < 5);
      cells = map_cells();
      for (int k = 0; k < 10; k++) begin
        idle_burst();
        if ($urandom_range(0, 3) == 0) begin
          write_cell($urandom_range(0, 1) ? $urandom_range(0, cells - 1)
                                          : $urandom_range(0, GridCells - 1),
                     $urandom_range(0, 99) < density);
        end else begin
          // long walks only where the whole map is cheap to fill
          span = (cells <= 4096 && $urandom_range(0, 4) == 0) ? 8191 : 63;
          r = mk(RowCast,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, GridCells - 1)
                                             : $urandom_range(0, cells - 1),
                 0, $urandom_range(0, span), $urandom_range(0, span),
                 pick_stride(eff_dim(width_reg)), pick_stride(eff_dim(width_reg)));
          cast_ray(r);
        end
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    wait (pending_rays.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d ray casts (%0d hits, %0d off-map), %0d cell writes",
             n_casts, n_hits, n_left, n_writes);
    $display("%0d register writes across several map shapes, %0d mismatches",
             n_cfg, errors);
    if (errors == 0) begin
      $display("grid_ray_cast_to_obstacle_core_tb: PASS");
    end else begin
      $display("grid_ray_cast_to_obstacle_core_tb: FAIL");
    end
    $finish;
  end

endmodule
